// ===== src/smoc_pkg.sv =====
package smoc_pkg;

  localparam int WINDOW     = 256;
  localparam int SAMPLE_W   = 32;
  localparam int COUNT_W    = 9;
  localparam int MIN_W      = 9;
  localparam int MAXOFF_W   = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  // held count reaches WINDOW itself, cell index and lap count stop at WINDOW-1
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_HELD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OFFSET = 1'd1;

  localparam logic [MIN_W-1:0]    MIN_HELD_RST   = 9'd5;
  localparam logic [MAXOFF_W-1:0] MAX_OFFSET_RST = 31'd4200;

  // value circulating around the ring, collecting its rank
  typedef struct packed {
    logic                vld;
    logic [SAMPLE_W-1:0] value;
    logic [IDX_W-1:0]    idx;
    logic [CNT_W-1:0]    rank;
  } token_t;

  typedef struct packed {
    logic load;   // shift a new item into the row, restart tokens
    logic step;   // move tokens one cell around the ring
    logic accum;  // count comparisons while stepping
  } ctrl_t;

endpackage

// ===== src/smoc_if.sv =====
interface smoc_in_if;
  logic                          valid;
  logic                          ready;
  logic [smoc_pkg::SAMPLE_W-1:0] sample_offset;

  modport source(output valid, output sample_offset, input ready);
  modport sink(input valid, input sample_offset, output ready);
endinterface

interface smoc_out_if;
  logic                          valid;
  logic                          ready;
  logic [smoc_pkg::SAMPLE_W-1:0] adjusted_offset;
  logic [smoc_pkg::COUNT_W-1:0]  sample_count;

  modport source(output valid, output adjusted_offset, output sample_count, input ready);
  modport sink(input valid, input adjusted_offset, input sample_count, output ready);
endinterface

// ===== src/smoc_cell.sv =====
module smoc_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smoc_pkg::ctrl_t               ctrl,
  input  logic [smoc_pkg::IDX_W-1:0]    cell_idx,
  input  logic                          sh_vld,
  input  logic [smoc_pkg::SAMPLE_W-1:0] sh_val,
  output logic                          vld_o,
  output logic [smoc_pkg::SAMPLE_W-1:0] val_o,
  input  smoc_pkg::token_t              tok_i,
  output smoc_pkg::token_t              tok_o
);

  logic                          vld_r;
  logic [smoc_pkg::SAMPLE_W-1:0] val_r;
  smoc_pkg::token_t              tok_r;
  smoc_pkg::token_t              tok_nxt;
  logic                          less;
  logic                          hit;

  // incoming token ranks above this cell's sample (ties broken by position)
  assign less = ($signed(val_r) < $signed(tok_i.value)) ||
                ((val_r == tok_i.value) && (cell_idx < tok_i.idx));
  assign hit  = ctrl.accum && vld_r && tok_i.vld && less;

  always_comb begin
    tok_nxt      = tok_i;
    tok_nxt.rank = tok_i.rank + smoc_pkg::CNT_W'(hit);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      val_r       <= sh_val;
      tok_r.value <= sh_val;
      tok_r.idx   <= cell_idx;
      tok_r.rank  <= '0;
    end else if (ctrl.step) begin
      tok_r.value <= tok_nxt.value;
      tok_r.idx   <= tok_nxt.idx;
      tok_r.rank  <= tok_nxt.rank;
    end
    if (!rst_n) begin
      vld_r     <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (ctrl.load) begin
      vld_r     <= sh_vld;
      tok_r.vld <= sh_vld;
    end else if (ctrl.step) begin
      tok_r.vld <= tok_nxt.vld;
    end
  end

  assign vld_o = vld_r;
  assign val_o = val_r;
  assign tok_o = tok_r;

endmodule

// ===== src/smoc_chain.sv =====
module smoc_chain (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smoc_pkg::ctrl_t               ctrl,
  input  logic [smoc_pkg::SAMPLE_W-1:0] new_val,
  output smoc_pkg::token_t              tap_tok
);

  logic                          vld_w [smoc_pkg::WINDOW];
  logic [smoc_pkg::SAMPLE_W-1:0] val_w [smoc_pkg::WINDOW];
  smoc_pkg::token_t              tok_w [smoc_pkg::WINDOW];

  genvar i;
  generate
    for (i = 0; i < smoc_pkg::WINDOW; i++) begin : g_cell
      logic                          sh_vld;
      logic [smoc_pkg::SAMPLE_W-1:0] sh_val;

      if (i == 0) begin : g_head
        assign sh_vld = 1'b1;
        assign sh_val = new_val;
      end else begin : g_body
        assign sh_vld = vld_w[i-1];
        assign sh_val = val_w[i-1];
      end

      smoc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cell_idx (smoc_pkg::IDX_W'(i)),
        .sh_vld   (sh_vld),
        .sh_val   (sh_val),
        .vld_o    (vld_w[i]),
        .val_o    (val_w[i]),
        .tok_i    (tok_w[(i + smoc_pkg::WINDOW - 1) % smoc_pkg::WINDOW]),
        .tok_o    (tok_w[i])
      );
    end
  endgenerate

  assign tap_tok = tok_w[smoc_pkg::WINDOW-1];

endmodule

// ===== src/sliding_median_offset_clamp_top.sv =====
// channel   dir  handshake       payload
// in_ch     in   valid / ready   sample_offset (s32)
// out_ch    out  valid / ready   adjusted_offset (s32), sample_count (u9)
// cfg       in   cfg_we          cfg_idx (0 sample floor, 1 max_offset), cfg_wdata
//
// each item is shifted into the cell row, then one ring lap ranks every held sample,
// a second lap picks the token whose rank is count/2 at the tap, and the result is
// clamped into the output register.
// synchronous active-low reset empties the window and loads the register defaults.
// a waiting result does not block the next item; only a second finished result
// stalls in the clamp cycle until the output register frees up.
module sliding_median_offset_clamp_top (
  input  logic                            clk,
  input  logic                            rst_n,
  smoc_in_if.sink                         in_ch,
  smoc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [smoc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [smoc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LAP1 = 2'd1;
  localparam logic [1:0] ST_LAP2 = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [smoc_pkg::IDX_W-1:0] LAP_LAST = smoc_pkg::IDX_W'(smoc_pkg::WINDOW - 1);
  localparam logic [smoc_pkg::CNT_W-1:0] CNT_FULL = smoc_pkg::CNT_W'(smoc_pkg::WINDOW);

  logic [1:0]                    state_r, state_nxt;
  logic [smoc_pkg::IDX_W-1:0]    lap_r, lap_nxt;
  logic [smoc_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [smoc_pkg::MIN_W-1:0]    min_r;
  logic [smoc_pkg::MAXOFF_W-1:0] max_r;
  logic [smoc_pkg::SAMPLE_W-1:0] med_r;
  logic                          out_vld_r;
  logic [smoc_pkg::SAMPLE_W-1:0] out_off_r;
  logic [smoc_pkg::COUNT_W-1:0]  out_cnt_r;

  smoc_pkg::ctrl_t               ctrl;
  smoc_pkg::token_t              tap_tok;
  logic                          accept;
  logic                          out_free;
  logic [smoc_pkg::CNT_W-1:0]    target;
  logic [smoc_pkg::CMP_W-1:0]    cnt_wide;
  logic [smoc_pkg::CMP_W-1:0]    min_wide;
  logic signed [32:0]            med_x;
  logic signed [32:0]            lim_pos;
  logic signed [32:0]            lim_neg;
  logic signed [32:0]            clamped;
  logic [smoc_pkg::SAMPLE_W-1:0] result;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_vld_r || out_ch.ready;
  assign target   = cnt_r >> 1;

  // row of ranking cells
  smoc_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .new_val (in_ch.sample_offset),
    .tap_tok (tap_tok)
  );

  // sequencer: accept, rank lap, pick lap, deliver
  always_comb begin
    state_nxt  = state_r;
    lap_nxt    = lap_r;
    cnt_nxt    = cnt_r;
    ctrl.load  = 1'b0;
    ctrl.step  = 1'b0;
    ctrl.accum = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ctrl.load = 1'b1;
          lap_nxt   = '0;
          state_nxt = ST_LAP1;
          if (cnt_r < CNT_FULL) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_LAP1: begin
        ctrl.step  = 1'b1;
        ctrl.accum = 1'b1;
        lap_nxt    = lap_r + 1'b1;
        if (lap_r == LAP_LAST) begin
          lap_nxt   = '0;
          state_nxt = ST_LAP2;
        end
      end
      ST_LAP2: begin
        ctrl.step = 1'b1;
        lap_nxt   = lap_r + 1'b1;
        if (lap_r == LAP_LAST) begin
          lap_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lap_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      lap_r   <= lap_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= smoc_pkg::MIN_HELD_RST;
      max_r <= smoc_pkg::MAX_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        smoc_pkg::REG_MIN_HELD:   min_r <= cfg_wdata[smoc_pkg::MIN_W-1:0];
        smoc_pkg::REG_MAX_OFFSET: max_r <= cfg_wdata[smoc_pkg::MAXOFF_W-1:0];
        default: ;
      endcase
    end
  end

  // each token passes the tap once during the pick lap; ranks are unique
  always_ff @(posedge clk) begin
    if (state_r == ST_LAP2 && tap_tok.vld && tap_tok.rank == target) begin
      med_r <= tap_tok.value;
    end
  end

  // clamp to +/- max_offset, zero while too few samples
  assign cnt_wide = smoc_pkg::CMP_W'(cnt_r);
  assign min_wide = smoc_pkg::CMP_W'(min_r);
  assign med_x    = 33'(signed'(med_r));
  assign lim_pos  = signed'({2'b00, max_r});
  assign lim_neg  = -lim_pos;

  always_comb begin
    priority if (med_x > lim_pos) begin
      clamped = lim_pos;
    end else if (med_x < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = med_x;
    end
  end

  assign result = (cnt_wide >= min_wide) ? clamped[smoc_pkg::SAMPLE_W-1:0] : '0;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_off_r <= result;
      out_cnt_r <= cnt_wide[smoc_pkg::COUNT_W-1:0];
    end
  end

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = out_vld_r;
  assign out_ch.adjusted_offset = out_off_r;
  assign out_ch.sample_count    = out_cnt_r;

endmodule

// ===== verif/tb_sliding_median_offset_clamp_top.sv =====
module tb_sliding_median_offset_clamp_top;
  timeunit 1ns;
  timeprecision 1ps;

  // one item spends two ring laps plus load and clamp inside the block
  localparam int ITEM_CYCLES = 2 * smoc_pkg::WINDOW + 2;
  // quiet cycles after the last result before the next register write or the end
  localparam int SETTLE      = ITEM_CYCLES + 16;
  // long receiver hold-off, several items worth, so the block backs up
  localparam int HOLD_CYCLES = 6 * ITEM_CYCLES;
  // cycles with no handshake at all before the run is declared hung
  localparam int STALL_LIMIT = 40 * ITEM_CYCLES;

  typedef struct {
    logic [smoc_pkg::SAMPLE_W-1:0] adjusted_offset;
    logic [smoc_pkg::COUNT_W-1:0]  sample_count;
  } median_result_t;

  // keeps its own window of samples plus a sorted copy of it, and the
  // queue of medians still owed by the block
  class median_tracker;
    int                            ring [smoc_pkg::WINDOW];
    int                            ordered [$];
    int unsigned                   held;
    int unsigned                   oldest;
    logic [smoc_pkg::MIN_W-1:0]    need_cnt;
    logic [smoc_pkg::MAXOFF_W-1:0] max_offset;
    median_result_t                owed_medians [$];
    int                            mismatches;

    function new();
      held       = 0;
      oldest     = 0;
      need_cnt   = smoc_pkg::MIN_HELD_RST;
      max_offset = smoc_pkg::MAX_OFFSET_RST;
      mismatches = 0;
    endfunction

    // only the register's own width is kept from the write data
    function void write_reg(logic [smoc_pkg::CFG_IDX_W-1:0] idx,
                            logic [smoc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        smoc_pkg::REG_MIN_HELD:   need_cnt   = data[smoc_pkg::MIN_W-1:0];
        smoc_pkg::REG_MAX_OFFSET: max_offset = data[smoc_pkg::MAXOFF_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [smoc_pkg::SAMPLE_W-1:0] sample);
      int             value;
      int             evicted;
      int             pos;
      bit             found;
      longint         med;
      longint         lim;
      median_result_t r;
      value = int'(sample);
      if (held >= smoc_pkg::WINDOW) begin
        // window full: the oldest sample makes room
        evicted      = ring[oldest];
        ring[oldest] = value;
        oldest       = (oldest + 1) % smoc_pkg::WINDOW;
        pos   = 0;
        found = 0;
        while (!found && pos < ordered.size()) begin
          if (ordered[pos] == evicted) begin
            ordered.delete(pos);
            found = 1;
          end else begin
            pos++;
          end
        end
      end else begin
        ring[(oldest + held) % smoc_pkg::WINDOW] = value;
        held++;
      end
      pos = 0;
      while (pos < ordered.size() && ordered[pos] <= value) pos++;
      ordered.insert(pos, value);

      r.sample_count    = held[smoc_pkg::COUNT_W-1:0];
      r.adjusted_offset = '0;
      if (held >= need_cnt) begin
        med = ordered[held / 2];
        lim = max_offset;
        if (med > lim) begin
          med = lim;
        end else if (med < -lim) begin
          med = -lim;
        end
        r.adjusted_offset = med[smoc_pkg::SAMPLE_W-1:0];
      end
      owed_medians.insert(owed_medians.size(), r);
    endfunction

    function void check_result(logic [smoc_pkg::SAMPLE_W-1:0] adj,
                               logic [smoc_pkg::COUNT_W-1:0] cnt);
      median_result_t want;
      if (owed_medians.size() == 0) begin
        $error("result with no sample pending: adjusted_offset %0d sample_count %0d",
               $signed(adj), cnt);
        mismatches++;
        return;
      end
      want = owed_medians.pop_front();
      if (adj !== want.adjusted_offset) begin
        $error("adjusted_offset expected %0d actual %0d",
               $signed(want.adjusted_offset), $signed(adj));
        mismatches++;
      end
      if (cnt !== want.sample_count) begin
        $error("sample_count expected %0d actual %0d", want.sample_count, cnt);
        mismatches++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [smoc_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [smoc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // idle percentages for each side, changed per phase
  int send_idle_pct = 36;
  int recv_idle_pct = 73;
  // one-shot request for the long receiver hold-off
  bit hold_req = 0;
  // slowly wandering offset, like a real peer clock
  int drift_center = 0;

  median_tracker tracker = new();

  smoc_in_if  in_if();
  smoc_out_if out_if();

  sliding_median_offset_clamp_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // write both registers back to back, the tracker follows the same writes
  task automatic apply_settings(input logic [smoc_pkg::CFG_DATA_W-1:0] min_w,
                                input logic [smoc_pkg::CFG_DATA_W-1:0] max_w);
    cfg_we    <= 1'b1;
    cfg_idx   <= smoc_pkg::REG_MIN_HELD;
    cfg_wdata <= min_w;
    @(posedge clk);
    tracker.write_reg(smoc_pkg::REG_MIN_HELD, min_w);
    cfg_idx   <= smoc_pkg::REG_MAX_OFFSET;
    cfg_wdata <= max_w;
    @(posedge clk);
    tracker.write_reg(smoc_pkg::REG_MAX_OFFSET, max_w);
    cfg_we    <= 1'b0;
  endtask

  // offer one sample, with random gaps ahead of it, and wait for the handshake
  task automatic send_sample(input logic [smoc_pkg::SAMPLE_W-1:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.sample_offset <= sample;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    tracker.note_sample(sample);
  endtask

  // let every owed median come out, then give the block a quiet lap
  task automatic drain();
    in_if.valid <= 1'b0;
    while (tracker.owed_medians.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mix of full-range noise, values around the clamp limit, extremes and a
  // drifting realistic offset
  function automatic logic [smoc_pkg::SAMPLE_W-1:0] pick_sample(int unsigned lim);
    longint span;
    longint v;
    span = (lim > 32'h2000_0000) ? 64'sh2000_0000 : longint'(lim);
    case ($urandom_range(9))
      0, 1, 2: v = $urandom;
      3, 4, 5: v = longint'($urandom_range(0, 2 * span + 2)) - span - 1;
      6: begin
        case ($urandom_range(5))
          0:       v = 64'sh7FFF_FFFF;
          1:       v = -64'sh8000_0000;
          2:       v = 0;
          3:       v = -1;
          4:       v = lim;
          default: v = -longint'(lim) - 1;
        endcase
      end
      default: begin
        drift_center = drift_center + int'($urandom_range(64)) - 32;
        v = longint'(drift_center) + longint'($urandom_range(200)) - 100;
      end
    endcase
    return v[smoc_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic random_phase(input logic [smoc_pkg::CFG_DATA_W-1:0] min_w,
                              input logic [smoc_pkg::CFG_DATA_W-1:0] max_w,
                              input int n, input int spct, input int rpct,
                              input bit press);
    send_idle_pct = spct;
    recv_idle_pct = rpct;
    apply_settings(min_w, max_w);
    for (int k = 0; k < n; k++) begin
      // receiver goes quiet while the sender keeps pushing
      if (press && k == 16) hold_req = 1;
      send_sample(pick_sample(tracker.max_offset));
    end
    drain();
  endtask

  // result side: check what was accepted, then pick the next ready
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        tracker.check_result(out_if.adjusted_offset, out_if.sample_count);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // hang detector: any handshake on either channel resets the count
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    logic [smoc_pkg::SAMPLE_W-1:0] opening [10];
    logic [smoc_pkg::SAMPLE_W-1:0] tail [3];
    opening = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                32'd4201, 32'd4201, 32'd4201, -32'sd5000, -32'sd4200};
    tail    = '{32'd5, -32'sd5, 32'h7FFF_FFFF};

    in_if.valid         <= 1'b0;
    in_if.sample_offset <= '0;
    cfg_we              <= 1'b0;
    cfg_idx             <= smoc_pkg::REG_MIN_HELD;
    cfg_wdata           <= '0;
    rst_n               <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: first four items too few, fifth reports, then clamp at 4200
    foreach (opening[i]) send_sample(opening[i]);
    drain();

    // zero sample floor from a wide write, zero max_offset: always zero
    apply_settings(31'h7FFF_FE00, 31'd0);
    foreach (tail[i]) send_sample(tail[i]);
    drain();

    // most negative samples take the median, clamped to the widest limit
    apply_settings(31'd1, 31'h7FFF_FFFF);
    repeat (12) send_sample(32'h8000_0000);
    drain();

    // sender sparse-ish, receiver mostly stalling
    random_phase(31'h7FFF_FE05, 31'd4200,       130, 36, 73, 0);
    random_phase(31'd0,         31'h7FFF_FFFF, 130, 36, 73, 0);
    random_phase(31'd256,       31'd0,         130, 36, 73, 0);
    // sender mostly idle, receiver occasionally
    random_phase(31'd1,         31'd1000,      130, 73, 36, 0);
    random_phase(31'h1FF,       31'h7FFF_FFFF, 60,  73, 36, 0);
    random_phase(31'd257,       31'd12345,     60,  73, 36, 0);
    // back to back, one long receiver hold-off in the first of these
    random_phase(31'd100,       31'h4000_0000, 200, 0,  0,  1);
    random_phase(31'd0,         31'd1,         200, 0,  0,  0);
    random_phase(31'd200,       31'h7FFF_FFFE, 130, 0,  0,  0);

    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
